// ----- sv/wfrm_pkg.sv -----
// ----------------------------------------------------------------------------
// wfrm_pkg: shared constants and helpers of the windowed frame rate meter
// sizes of the timestamp ring, field widths and the ring index arithmetic
// ----------------------------------------------------------------------------
package wfrm_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned STAMP_BITS = 48;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned RATE_W     = 36;
  localparam int unsigned STEP_W     = $clog2(STAMP_BITS);

  localparam logic [CNT_W-1:0]      LEN_RESET      = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0]      LEN_MIN        = CNT_W'(2);
  localparam logic [RATE_W-1:0]     US_PER_SEC_Q16 = RATE_W'(64'd65536000000);
  localparam logic [RATE_W-1:0]     RATE_SAT       = '1;
  localparam logic [STEP_W-1:0]     LAST_STEP      = STEP_W'(STAMP_BITS - 1);

  // clamp the programmed window length to 2..DEPTH
  function automatic logic [CNT_W-1:0] eff_len(input logic [CNT_W-1:0] wl);
    logic [CNT_W-1:0] n;
    n = wl;
    if (n < LEN_MIN) n = LEN_MIN;
    if (n > LEN_RESET) n = LEN_RESET;
    return n;
  endfunction

  // next ring slot, wrapping at the window length
  function automatic logic [IDX_W-1:0] ring_adv(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] len);
    logic [CNT_W-1:0] nxt;
    nxt = CNT_W'(idx) + CNT_W'(1);
    return (nxt >= len) ? '0 : IDX_W'(nxt);
  endfunction

endpackage

// ----- sv/wfrm_if.sv -----
// ----------------------------------------------------------------------------
// wfrm interfaces: request channels of the windowed frame rate meter
// frame timestamps in, measurement results out, window length writes
// ----------------------------------------------------------------------------
interface wfrm_stamp_if
  import wfrm_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [STAMP_BITS-1:0] timestamp_us;
  modport source (output valid, output timestamp_us, input ready);
  modport sink   (input valid, input timestamp_us, output ready);
endinterface

interface wfrm_result_if
  import wfrm_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CNT_W-1:0]      frames_in_window;
  logic [STAMP_BITS-1:0] avg_period_us;
  logic [RATE_W-1:0]     rate_fps_q16;
  logic                  rate_valid;
  modport source (output valid, output frames_in_window, output avg_period_us,
                  output rate_fps_q16, output rate_valid, input ready);
  modport sink   (input valid, input frames_in_window, input avg_period_us,
                  input rate_fps_q16, input rate_valid, output ready);
endinterface

interface wfrm_cfg_if
  import wfrm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] window_len;
  modport source (output valid, output window_len, input ready);
  modport sink   (input valid, input window_len, output ready);
endinterface

// ----- sv/windowed_frame_rate_meter.sv -----
// ----------------------------------------------------------------------------
// windowed_frame_rate_meter: moving window frame period and rate
// averages frame timestamps over a ring of the last window_len arrivals
// ----------------------------------------------------------------------------
// sequence: a lone frame goes straight to the output; otherwise ring read,
//   subtract, a 48-step period division, a 48-step rate division unless the
//   period is zero, output; one frame request at a time on the single shared
//   restoring divider, the next taken once the result is in the output register
// reset: window length returns to 16, the window is emptied, no result pending;
//   the ring contents are not cleared, only slots written since are ever read
module windowed_frame_rate_meter
  import wfrm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  wfrm_stamp_if.sink   in_i,
  wfrm_result_if.source out_o,
  wfrm_cfg_if.sink     cfg_i
);

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0; // waiting for a frame or a config write
  localparam logic [2:0] ST_READ = 3'd1; // fetch oldest timestamp from the ring
  localparam logic [2:0] ST_SUB  = 3'd2; // newest minus oldest, start period division
  localparam logic [2:0] ST_DIV  = 3'd3; // one quotient bit per cycle
  localparam logic [2:0] ST_FIN  = 3'd4; // hand result to the output register

  // control state
  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  wlen_q, wlen_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              pass_q, pass_d;    // 0: period division, 1: rate division
  logic              out_vld_q, out_vld_d;

  // payload / datapath registers
  logic [STAMP_BITS-1:0] ring_mem [DEPTH];
  logic [STAMP_BITS-1:0] newest_q;
  logic [STAMP_BITS-1:0] oldest_q;
  logic [STAMP_BITS-1:0] acc_q, acc_d;   // dividend shifting out, quotient shifting in
  logic [STAMP_BITS-1:0] rem_q, rem_d;
  logic [STAMP_BITS-1:0] dvs_q, dvs_d;
  logic [STAMP_BITS-1:0] per_q, per_d;
  logic [RATE_W-1:0]     rate_q, rate_d;
  logic                  rvld_q, rvld_d;
  logic [CNT_W-1:0]      o_frames_q;
  logic [STAMP_BITS-1:0] o_period_q;
  logic [RATE_W-1:0]     o_rate_q;
  logic                  o_rvld_q;

  logic [CNT_W-1:0] len;
  logic             in_take;
  logic             cfg_take;
  logic             out_load;
  logic             ring_full;
  logic [STAMP_BITS:0]   trial;
  logic                  q_bit;
  logic [STAMP_BITS-1:0] rem_step;
  logic [STAMP_BITS-1:0] acc_step;

  assign len       = eff_len(wlen_q);
  assign ring_full = (count_q == len);

  // config writes and frames are only taken between frames; config wins
  assign cfg_i.ready = (state_q == ST_IDLE);
  assign in_i.ready  = (state_q == ST_IDLE) && !cfg_i.valid;
  assign cfg_take    = cfg_i.valid && cfg_i.ready;
  assign in_take     = in_i.valid && in_i.ready;

  // output register frees itself as the sink takes it
  assign out_load = (state_q == ST_FIN) && (!out_vld_q || out_o.ready);

  // shared restoring divider step
  assign trial    = {rem_q, acc_q[STAMP_BITS-1]} - {1'b0, dvs_q};
  assign q_bit    = !trial[STAMP_BITS];
  assign rem_step = q_bit ? trial[STAMP_BITS-1:0]
                          : {rem_q[STAMP_BITS-2:0], acc_q[STAMP_BITS-1]};
  assign acc_step = {acc_q[STAMP_BITS-2:0], q_bit};

  always_comb begin
    state_d   = state_q;
    wlen_d    = wlen_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    step_d    = step_q;
    pass_d    = pass_q;
    out_vld_d = out_vld_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    dvs_d     = dvs_q;
    per_d     = per_q;
    rate_d    = rate_q;
    rvld_d    = rvld_q;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (cfg_take) begin
          // a new window length also empties the window
          wlen_d  = cfg_i.window_len;
          head_d  = '0;
          tail_d  = '0;
          count_d = '0;
        end else if (in_take) begin
          // drop the oldest stamp first when the window is full
          if (ring_full) begin
            head_d = ring_adv(head_q, len);
          end else begin
            count_d = count_q + CNT_W'(1);
          end
          tail_d = ring_adv(tail_q, len);
          per_d  = '0;
          rate_d = '0;
          rvld_d = 1'b0;
          // lone frame: nothing to average
          state_d = (ring_full || count_q != '0) ? ST_READ : ST_FIN;
        end
      end
      ST_READ: begin
        state_d = ST_SUB;
      end
      ST_SUB: begin
        acc_d   = newest_q - oldest_q;
        rem_d   = '0;
        dvs_d   = STAMP_BITS'(count_q - CNT_W'(1));
        step_d  = '0;
        pass_d  = 1'b0;
        rvld_d  = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        acc_d  = acc_step;
        rem_d  = rem_step;
        step_d = step_q + STEP_W'(1);
        if (step_q == LAST_STEP) begin
          if (!pass_q) begin
            per_d = acc_step;
            if (acc_step == '0) begin
              // zero period saturates the rate
              rate_d  = RATE_SAT;
              state_d = ST_FIN;
            end else begin
              acc_d  = STAMP_BITS'(US_PER_SEC_Q16);
              rem_d  = '0;
              dvs_d  = acc_step;
              step_d = '0;
              pass_d = 1'b1;
            end
          end else begin
            rate_d  = acc_step[RATE_W-1:0];
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (out_load) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wlen_q    <= LEN_RESET;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      step_q    <= '0;
      pass_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wlen_q    <= wlen_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      step_q    <= step_d;
      pass_q    <= pass_d;
      out_vld_q <= out_vld_d;
    end
  end

  // ring store: one write on accept, one registered read of the oldest slot
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ring_mem[tail_q] <= in_i.timestamp_us;
      newest_q         <= in_i.timestamp_us;
    end
    if (state_q == ST_READ) begin
      oldest_q <= ring_mem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    per_q  <= per_d;
    rate_q <= rate_d;
    rvld_q <= rvld_d;
    if (out_load) begin
      o_frames_q <= count_q;
      o_period_q <= per_q;
      o_rate_q   <= rate_q;
      o_rvld_q   <= rvld_q;
    end
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.frames_in_window = o_frames_q;
  assign out_o.avg_period_us    = o_period_q;
  assign out_o.rate_fps_q16     = o_rate_q;
  assign out_o.rate_valid       = o_rvld_q;

  // fill level never exceeds the window
  a_count_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= len)
    else $error("stamp count above window length");

  // ring pointers stay inside the window
  a_idx_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CNT_W'(head_q) < len) && (CNT_W'(tail_q) < len))
    else $error("ring pointer outside window");

  // an empty or full window has head and tail on the same slot
  a_empty_full_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == len) |-> (head_q == tail_q))
    else $error("head and tail disagree with fill level");

  // a result without a rate comes only from a lone frame
  a_lone_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !o_rvld_q) |-> (o_frames_q == CNT_W'(1)))
    else $error("rate invalid with more than one frame");

endmodule

// ----- sim/windowed_frame_rate_meter_tb.sv -----
// ----------------------------------------------------------------------------
// windowed_frame_rate_meter_tb: self-checking bench of the frame rate meter
// feeds timestamp requests through bursts and gaps, stalls the result side on
// a pattern of its own, predicts every window measurement in the bench and
// compares each result field by field, over several window length settings
// ----------------------------------------------------------------------------
module windowed_frame_rate_meter_tb;
  import wfrm_pkg::*;

  // one million microseconds per second in Q16.16
  localparam logic [63:0] USEC_Q16 = 64'd65536000000;

  // window lengths of the random phases, extremes and out-of-range codes too
  localparam int unsigned N_PHASES = 12;
  localparam logic [CNT_W-1:0] PHASE_LENS [N_PHASES] = '{
    5'd16, 5'd2, 5'd3, 5'd1, 5'd0, 5'd31, 5'd17, 5'd8, 5'd5, 5'd16, 5'd12, 5'd7
  };
  localparam int unsigned FRAMES_PER_PHASE = 160;

  typedef struct packed {
    logic [CNT_W-1:0]      frames;
    logic [STAMP_BITS-1:0] period;
    logic [RATE_W-1:0]     rate;
    logic                  valid;
  } meas_t;

  // receiver behaviour over one stretch of cycles
  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_SPARSE,
    RX_HOLD
  } rx_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  wfrm_stamp_if  stamp_ch ();
  wfrm_result_if meas_ch ();
  wfrm_cfg_if    win_ch ();

  windowed_frame_rate_meter u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (stamp_ch),
    .out_o  (meas_ch),
    .cfg_i  (win_ch)
  );

  always #4 clk_i = ~clk_i;

  // bench copy of the meter state
  logic [CNT_W-1:0]      win_len_q;
  logic [STAMP_BITS-1:0] stamp_ring_q [DEPTH];
  int unsigned           head_q;
  int unsigned           tail_q;
  int unsigned           count_q;

  logic [STAMP_BITS-1:0] pending_stamps [$];
  meas_t                 expected_meas [$];
  int unsigned           mismatches;

  // driver and receiver bookkeeping
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned seg_left;
  int unsigned seg_num;
  rx_mode_e    seg_mode;
  meas_t       want;

  function automatic int unsigned wrap_next(input int unsigned idx, input int unsigned len);
    return (idx + 1 >= len) ? 0 : idx + 1;
  endfunction

  // one frame arrival: update the window and work out its measurement
  function automatic meas_t meter_frame(input logic [STAMP_BITS-1:0] ts);
    meas_t                 m;
    int unsigned           len;
    int unsigned           last;
    logic [STAMP_BITS-1:0] span;
    logic [63:0]           per;
    m   = '0;
    len = win_len_q;
    // lengths 0 and 1 act as 2, anything past the ring depth as the depth
    if (len < 2) len = 2;
    if (len > DEPTH) len = DEPTH;
    // full window: drop the oldest stamp first
    if (count_q == len) begin
      head_q  = wrap_next(head_q, len);
      count_q = count_q - 1;
    end
    stamp_ring_q[tail_q] = ts;
    tail_q  = wrap_next(tail_q, len);
    count_q = count_q + 1;
    m.frames = CNT_W'(count_q);
    // a lone frame has no period, everything else reports one
    if (count_q >= 2) begin
      last = (tail_q == 0) ? len - 1 : tail_q - 1;
      // span wraps modulo the stamp width
      span = stamp_ring_q[last] - stamp_ring_q[head_q];
      per  = 64'(span) / 64'(count_q - 1);
      m.period = per[STAMP_BITS-1:0];
      // zero period saturates the rate
      m.rate   = (per == 0) ? '1 : RATE_W'(USEC_Q16 / per);
      m.valid  = 1'b1;
    end
    return m;
  endfunction

  function automatic logic [STAMP_BITS-1:0] rand_stamp();
    return STAMP_BITS'({$urandom, $urandom});
  endfunction

  // ------------------------------------------------------------------------
  // request driver: bursts of random length, random gaps, 0 gap half the time
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stamp_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (stamp_ch.valid && stamp_ch.ready) begin
        expected_meas.push_back(meter_frame(stamp_ch.timestamp_us));
        void'(pending_stamps.pop_front());
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 250);
      end
      // a request still waiting for ready is held as it is
      if (!stamp_ch.valid || stamp_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          stamp_ch.valid <= 1'b0;
        end else if (pending_stamps.size() != 0) begin
          if (burst_left == 0) burst_left = $urandom_range(1, 24);
          stamp_ch.valid        <= 1'b1;
          stamp_ch.timestamp_us <= pending_stamps[0];
        end else begin
          stamp_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // result ready pattern: free, random and sparse stretches, and every
  // sixteenth stretch a long hold-off so the block backs up its input
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      meas_ch.ready <= 1'b0;
      seg_left = 0;
      seg_num  = 0;
      seg_mode = RX_FREE;
    end else begin
      if (seg_left == 0) begin
        seg_num++;
        if (seg_num % 16 == 5) begin
          seg_mode = RX_HOLD;
          seg_left = $urandom_range(300, 600);
        end else begin
          seg_mode = rx_mode_e'($urandom_range(0, 2));
          seg_left = $urandom_range(20, 300);
        end
      end
      seg_left--;
      case (seg_mode)
        RX_FREE:   meas_ch.ready <= 1'b1;
        RX_RANDOM: meas_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: meas_ch.ready <= (seg_left % 4 == 0);
        default:   meas_ch.ready <= 1'b0;
      endcase
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // ------------------------------------------------------------------------
  // result monitor: each accepted result against the oldest prediction
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && meas_ch.valid && meas_ch.ready) begin
      if (expected_meas.size() == 0) begin
        $error("result with no request outstanding: frames %0d period %0d",
               meas_ch.frames_in_window, meas_ch.avg_period_us);
        mismatches++;
      end else begin
        want = expected_meas.pop_front();
        check_field("frames_in_window", 64'(want.frames), 64'(meas_ch.frames_in_window));
        check_field("avg_period_us", 64'(want.period), 64'(meas_ch.avg_period_us));
        check_field("rate_fps_q16", 64'(want.rate), 64'(meas_ch.rate_fps_q16));
        check_field("rate_valid", 64'(want.valid), 64'(meas_ch.rate_valid));
      end
    end
  end

  // wait until every queued request has been answered
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_stamps.size() != 0 || expected_meas.size() != 0);
  endtask

  // window length write, only ever issued with the block idle
  task automatic write_window(input logic [CNT_W-1:0] len);
    wait_drained();
    repeat (4) @(posedge clk_i);
    win_ch.valid      <= 1'b1;
    win_ch.window_len <= len;
    do @(posedge clk_i);
    while (!win_ch.ready);
    // any write empties the window
    win_len_q = len;
    head_q    = 0;
    tail_q    = 0;
    count_q   = 0;
    win_ch.valid <= 1'b0;
  endtask

  // one stream of frames at a nominal period, with duplicates, random
  // stamps and backward jumps mixed in
  task automatic queue_run(input int unsigned n);
    logic [STAMP_BITS-1:0] ts;
    logic [STAMP_BITS-1:0] nominal;
    int unsigned           r;
    ts = $urandom_range(0, 3) == 0 ? ~STAMP_BITS'($urandom_range(0, 200000)) : rand_stamp();
    case ($urandom_range(0, 3))
      0:       nominal = STAMP_BITS'($urandom_range(0, 3));
      1:       nominal = STAMP_BITS'($urandom_range(8000, 50000));
      2:       nominal = STAMP_BITS'({$urandom_range(0, 255), $urandom});
      default: nominal = STAMP_BITS'({$urandom_range(0, 65535), $urandom});
    endcase
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 80) ts = ts + nominal + STAMP_BITS'($urandom_range(0, 999));
      else if (r < 94 && r >= 88) ts = rand_stamp();
      else if (r >= 94) ts = ts - STAMP_BITS'($urandom_range(1, 1000));
      pending_stamps.push_back(ts);
    end
  endtask

  // ------------------------------------------------------------------------
  // stimulus: directed corners first, then random phases per window length
  // ------------------------------------------------------------------------
  initial begin
    int unsigned left;
    int unsigned run;
    stamp_ch.valid        = 1'b0;
    stamp_ch.timestamp_us = '0;
    meas_ch.ready         = 1'b0;
    win_ch.valid          = 1'b0;
    win_ch.window_len     = '0;
    win_len_q  = 5'd16;
    head_q     = 0;
    tail_q     = 0;
    count_q    = 0;
    mismatches = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset length: lone frame, zero period, widest stamp, wrap to a tiny span
    pending_stamps.push_back('0);
    pending_stamps.push_back('0);
    pending_stamps.push_back('1);
    pending_stamps.push_back(STAMP_BITS'(1));

    // shortest window: wrap, unit period, span of all ones, zero period
    write_window(5'd2);
    pending_stamps.push_back(48'hFFFF_FFFF_FFF0);
    pending_stamps.push_back(48'h0000_0000_0010);
    pending_stamps.push_back(48'h0000_0000_0011);
    pending_stamps.push_back(48'h0000_0000_0010);
    pending_stamps.push_back(48'h0000_0000_0010);

    // out-of-range lengths clamp to 2 and to the ring depth
    write_window(5'd0);
    pending_stamps.push_back(STAMP_BITS'(5));
    pending_stamps.push_back(STAMP_BITS'(7));
    pending_stamps.push_back(STAMP_BITS'(9));
    write_window(5'd1);
    pending_stamps.push_back(STAMP_BITS'(100));
    pending_stamps.push_back(STAMP_BITS'(200));
    write_window(5'd31);
    pending_stamps.push_back(48'h5555_5555_5555);
    pending_stamps.push_back(48'hAAAA_AAAA_AAAA);
    pending_stamps.push_back(48'h0000_0000_0000);
    write_window(5'd17);
    pending_stamps.push_back(48'h8000_0000_0000);
    pending_stamps.push_back(48'h7FFF_FFFF_FFFF);

    // random phases, the sender pausing for a full drain between them
    for (int unsigned p = 0; p < N_PHASES; p++) begin
      write_window(PHASE_LENS[p]);
      left = FRAMES_PER_PHASE;
      while (left > 0) begin
        run = $urandom_range(8, 60);
        if (run > left) run = left;
        queue_run(run);
        left -= run;
      end
    end

    wait_drained();
    // settle time for any stray result
    repeat (300) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- windowed_frame_rate_meter.f -----
sv/wfrm_pkg.sv
sv/wfrm_if.sv
sv/windowed_frame_rate_meter.sv
sim/windowed_frame_rate_meter_tb.sv
